// File: sv/tkd_pkg.sv
// Package for the two-key debounce block: key event codes, phase codes,
// configuration defaults and the configuration register bundle.
// No dependencies; every other file of the block uses it.
package tkd_pkg;

    // Key event reported for each tick item.
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_SEL  = 2'd1,
        EV_INC  = 2'd2
    } t_key_event;

    // Debounce phase, one-hot coded.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_WAIT   = 3'b010,
        PH_REPEAT = 3'b100
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_RELEASE_TICKS = 2'd0,
        CFG_LONG_PRESS    = 2'd1,
        CFG_REPEAT_TICKS  = 2'd2
    } t_cfg_idx;

    localparam int REL_W  = 7;
    localparam int HOLD_W = 16;
    localparam int CFG_W  = 16;

    localparam logic [REL_W-1:0]  RELEASE_TICKS_RST = 7'd100;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RST    = 16'd1000;
    localparam logic [HOLD_W-1:0] REPEAT_TICKS_RST  = 16'd100;

    // Configuration registers as seen by the state logic.
    typedef struct packed {
        logic [REL_W-1:0]  release_ticks;
        logic [HOLD_W-1:0] long_press_ticks;
        logic [HOLD_W-1:0] repeat_ticks;
    } t_cfg;

endpackage

// File: sv/tkd_if.sv
// Valid/ready channel interfaces of the two-key debounce block: key tick
// items in, key event items out. Depends on tkd_pkg.
interface tkd_key_if;
    logic valid;
    logic ready;
    logic inc_pressed;
    logic sel_pressed;

    modport source (output valid, output inc_pressed, output sel_pressed, input ready);
    modport sink   (input valid, input inc_pressed, input sel_pressed, output ready);
endinterface

interface tkd_evt_if;
    logic                  valid;
    logic                  ready;
    tkd_pkg::t_key_event   key_event;

    modport source (output valid, output key_event, input ready);
    modport sink   (input valid, input key_event, output ready);
endinterface

// File: sv/tkd_cfg_regs.sv
// Configuration registers of the two-key debounce block, written through a
// plain write port. Depends on tkd_pkg.
module tkd_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [tkd_pkg::CFG_W-1:0]  i_cfg_data,
    output tkd_pkg::t_cfg              o_cfg
);
    import tkd_pkg::*;

    t_cfg r_cfg;

    // Writes to an index beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.release_ticks    <= RELEASE_TICKS_RST;
            r_cfg.long_press_ticks <= LONG_PRESS_RST;
            r_cfg.repeat_ticks     <= REPEAT_TICKS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RELEASE_TICKS: r_cfg.release_ticks    <= i_cfg_data[REL_W-1:0];
                CFG_LONG_PRESS:    r_cfg.long_press_ticks <= i_cfg_data[HOLD_W-1:0];
                CFG_REPEAT_TICKS:  r_cfg.repeat_ticks     <= i_cfg_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/tkd_step.sv
// Debounce state machine: phase, release and hold counters, and the result
// register that holds the key event of the last processed item.
// Depends on tkd_pkg.
module tkd_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_inc,
    input  logic                 i_sel,
    input  tkd_pkg::t_cfg        i_cfg,
    output tkd_pkg::t_key_event  o_event
);
    import tkd_pkg::*;

    t_phase            r_phase,    n_phase;
    logic [REL_W-1:0]  r_rel_cnt,  n_rel_cnt;
    logic [HOLD_W-1:0] r_hold_cnt, n_hold_cnt;
    t_key_event        r_event,    n_event;

    logic [HOLD_W-1:0] hold_inc;
    logic [REL_W-1:0]  rel_inc;

    // Saturating increments of both counters.
    assign hold_inc = (r_hold_cnt == '1) ? r_hold_cnt : r_hold_cnt + 1'b1;
    assign rel_inc  = (r_rel_cnt == '1) ? r_rel_cnt : r_rel_cnt + 1'b1;

    // Next state and key event for one tick item.
    always_comb begin
        n_phase    = r_phase;
        n_rel_cnt  = r_rel_cnt;
        n_hold_cnt = r_hold_cnt;
        n_event    = EV_NONE;
        case (r_phase)
            PH_WAIT: begin
                if (r_rel_cnt >= i_cfg.release_ticks) begin
                    // The extra tick after the release count is reached.
                    n_phase   = PH_IDLE;
                    n_rel_cnt = '0;
                end else if (i_inc || i_sel) begin
                    n_rel_cnt  = REL_W'(1);
                    n_hold_cnt = hold_inc;
                    if (hold_inc > i_cfg.long_press_ticks) begin
                        n_phase   = PH_REPEAT;
                        n_rel_cnt = '0;
                    end
                end else begin
                    n_rel_cnt = rel_inc;
                end
            end
            PH_REPEAT: begin
                if (i_inc) begin
                    if (hold_inc > i_cfg.repeat_ticks) begin
                        n_event    = EV_INC;
                        n_hold_cnt = '0;
                    end else begin
                        n_hold_cnt = hold_inc;
                    end
                end else begin
                    n_phase   = PH_IDLE;
                    n_rel_cnt = '0;
                end
            end
            default: begin
                // Idle; increment wins over select.
                n_phase    = PH_IDLE;
                n_hold_cnt = '0;
                if (i_inc) begin
                    n_event   = EV_INC;
                    n_phase   = PH_WAIT;
                    n_rel_cnt = REL_W'(1);
                end else if (i_sel) begin
                    n_event   = EV_SEL;
                    n_phase   = PH_WAIT;
                    n_rel_cnt = REL_W'(1);
                end
            end
        endcase
    end

    // State registers move only when an item is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_rel_cnt  <= '0;
            r_hold_cnt <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_rel_cnt  <= n_rel_cnt;
            r_hold_cnt <= n_hold_cnt;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_event <= n_event;
        end
    end

    assign o_event = r_event;

endmodule

// File: sv/two_key_debounce_auto_repeat.sv
// Two-key debounce with auto-repeat: each key tick item (one 2 ms tick with
// the increment and select key levels, 1 = pressed) yields exactly one key
// event item: none, select or increment. The block takes one item per clock
// cycle while the output is not stalled: an item is registered at the input,
// then its state update and event are computed into the result register once
// that is free, and the event is offered on the output from there. Input and
// result registers let a new item enter while an event waits to be taken.
// Configuration registers may be written only while no item is in flight.
// Depends on tkd_pkg, tkd_if, tkd_cfg_regs and tkd_step.
module two_key_debounce_auto_repeat (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tkd_key_if.sink                    i_key,
    tkd_evt_if.source                  o_evt,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [tkd_pkg::CFG_W-1:0]  i_cfg_data
);
    import tkd_pkg::*;

    logic r_in_vld;
    logic r_inc;
    logic r_sel;
    logic r_out_vld, n_out_vld;
    logic step;
    t_cfg cfg;
    t_key_event evt;

    // Handshake: the input register empties whenever its item can move into
    // the result register.
    assign step        = r_in_vld && (!r_out_vld || o_evt.ready);
    assign i_key.ready = !r_in_vld || step;
    assign n_out_vld   = step ? 1'b1 : (o_evt.ready ? 1'b0 : r_out_vld);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_key.ready) begin
                r_in_vld <= i_key.valid;
            end
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key.valid && i_key.ready) begin
            r_inc <= i_key.inc_pressed;
            r_sel <= i_key.sel_pressed;
        end
    end

    tkd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tkd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_inc   (r_inc),
        .i_sel   (r_sel),
        .i_cfg   (cfg),
        .o_event (evt)
    );

    assign o_evt.valid     = r_out_vld;
    assign o_evt.key_event = evt;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for two_key_debounce_auto_repeat: key ticks go in,
// key events are predicted per accepted tick and checked in order.
// Depends on tkd_pkg, tkd_if and the block itself.
module tb_top;
    import tkd_pkg::*;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic inc;
        logic sel;
    } t_tick;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    tkd_key_if key_if ();
    tkd_evt_if evt_if ();

    two_key_debounce_auto_repeat i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (key_if),
        .o_evt      (evt_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Ticks waiting to be offered and events waiting to come out.
    t_tick pending_ticks[$];
    t_key_event expected_events[$];
    t_tick next_tick;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int holdoff_req = 0;
    int holdoff_ack = 0;
    int holdoff_left = 0;

    // Predicted debounce state and its copy of the configuration.
    t_phase exp_phase = PH_IDLE;
    logic [REL_W-1:0] exp_release_cnt = '0;
    logic [HOLD_W-1:0] exp_hold_cnt = '0;
    logic [REL_W-1:0] cfg_release = RELEASE_TICKS_RST;
    logic [HOLD_W-1:0] cfg_long_press = LONG_PRESS_RST;
    logic [HOLD_W-1:0] cfg_repeat = REPEAT_TICKS_RST;

    // Advance the predicted state by one tick and return its key event.
    function automatic t_key_event debounce_step(input logic inc, input logic sel);
        t_key_event ev;
        ev = EV_NONE;
        case (exp_phase)
            PH_WAIT: begin
                if (exp_release_cnt >= cfg_release) begin
                    exp_phase = PH_IDLE;
                    exp_release_cnt = '0;
                end else if (inc || sel) begin
                    exp_release_cnt = REL_W'(1);
                    if (exp_hold_cnt != '1)
                        exp_hold_cnt = exp_hold_cnt + 1'b1;
                    if (exp_hold_cnt > cfg_long_press) begin
                        exp_phase = PH_REPEAT;
                        exp_release_cnt = '0;
                    end
                end else if (exp_release_cnt != '1) begin
                    exp_release_cnt = exp_release_cnt + 1'b1;
                end
            end
            PH_REPEAT: begin
                if (inc) begin
                    if (exp_hold_cnt != '1)
                        exp_hold_cnt = exp_hold_cnt + 1'b1;
                    if (exp_hold_cnt > cfg_repeat) begin
                        ev = EV_INC;
                        exp_hold_cnt = '0;
                    end
                end else begin
                    exp_phase = PH_IDLE;
                    exp_release_cnt = '0;
                end
            end
            default: begin
                exp_phase = PH_IDLE;
                exp_hold_cnt = '0;
                if (inc || sel) begin
                    ev = inc ? EV_INC : EV_SEL;
                    exp_phase = PH_WAIT;
                    exp_release_cnt = REL_W'(1);
                end
            end
        endcase
        return ev;
    endfunction

    // Clock.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Driver: offers queued ticks and predicts the event of each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_if.valid <= 1'b0;
            key_if.inc_pressed <= 1'b0;
            key_if.sel_pressed <= 1'b0;
        end else begin
            if (key_if.valid && key_if.ready)
                expected_events.push_back(
                    debounce_step(key_if.inc_pressed, key_if.sel_pressed));
            if (!key_if.valid || key_if.ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_tick = pending_ticks.pop_front();
                    key_if.valid <= 1'b1;
                    key_if.inc_pressed <= next_tick.inc;
                    key_if.sel_pressed <= next_tick.sel;
                end else begin
                    key_if.valid <= 1'b0;
                    key_if.inc_pressed <= 1'($urandom_range(1));
                    key_if.sel_pressed <= 1'($urandom_range(1));
                end
            end
        end
    end

    // Monitor: checks each accepted event and drives ready, with hold-offs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.ready <= 1'b0;
        end else begin
            if (evt_if.valid && evt_if.ready) begin
                if (expected_events.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected key event %0d with nothing pending",
                                 evt_if.key_event);
                end else if (evt_if.key_event !== expected_events[0]) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("key event mismatch: expected %0d, got %0d",
                                 expected_events[0], evt_if.key_event);
                    void'(expected_events.pop_front());
                end else begin
                    void'(expected_events.pop_front());
                end
            end
            if (holdoff_ack != holdoff_req) begin
                holdoff_ack <= holdoff_req;
                holdoff_left <= HOLDOFF_CYCLES;
                evt_if.ready <= 1'b0;
            end else if (holdoff_left != 0) begin
                holdoff_left <= holdoff_left - 1;
                evt_if.ready <= 1'b0;
            end else begin
                evt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((key_if.valid && key_if.ready) || (evt_if.valid && evt_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_tick(input logic inc, input logic sel);
        t_tick t;
        t.inc = inc;
        t.sel = sel;
        pending_ticks.push_back(t);
    endtask

    // One press of the chosen keys, then a release; jitter adds key bounce.
    task automatic press_and_release(input logic inc, input logic sel,
                                     input int hold_len, input int rel_len,
                                     input bit jitter);
        int r;
        for (int k = 0; k < hold_len; k++) begin
            r = $urandom_range(99);
            if (jitter && r < 5)
                push_tick(1'b0, 1'b0);
            else if (jitter && r < 12)
                push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                push_tick(inc, sel);
        end
        for (int k = 0; k < rel_len; k++) begin
            if (jitter && $urandom_range(99) < 5)
                push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                push_tick(1'b0, 1'b0);
        end
    endtask

    // Random presses sized around the current settings, with some noise ticks.
    task automatic gen_bursts(input int n_items);
        int made;
        int hold_len;
        int rel_len;
        int kind;
        int lp;
        int rp;
        int rl;
        made = 0;
        lp = (cfg_long_press > 60) ? 60 : cfg_long_press;
        rp = (cfg_repeat > 10) ? 10 : cfg_repeat;
        rl = cfg_release;
        while (made < n_items) begin
            if ($urandom_range(99) < 15) begin
                push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                made++;
            end else begin
                kind = $urandom_range(2);
                case ($urandom_range(3))
                    0: hold_len = $urandom_range(3);
                    1: hold_len = lp + $urandom_range(2);
                    2: hold_len = lp + 1 + $urandom_range(4) * (rp + 1) + $urandom_range(1);
                    default: hold_len = $urandom_range(40);
                endcase
                if ($urandom_range(1))
                    rel_len = rl + $urandom_range(2);
                else
                    rel_len = $urandom_range(rl + 3);
                press_and_release(kind != 1, kind != 0, hold_len, rel_len, 1'b1);
                made += hold_len + rel_len;
            end
        end
    endtask

    // Wait until every tick is accepted and every event has arrived.
    task automatic drain();
        @(negedge i_clk);
        while (pending_ticks.size() != 0 || key_if.valid || expected_events.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RELEASE_TICKS: cfg_release = data[REL_W-1:0];
            CFG_LONG_PRESS:    cfg_long_press = data[HOLD_W-1:0];
            default:           cfg_repeat = data[HOLD_W-1:0];
        endcase
    endtask

    task automatic set_cfg(input logic [CFG_W-1:0] rel, input logic [CFG_W-1:0] lp,
                           input logic [CFG_W-1:0] rp);
        write_cfg(CFG_RELEASE_TICKS, rel);
        write_cfg(CFG_LONG_PRESS, lp);
        write_cfg(CFG_REPEAT_TICKS, rp);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Test sequence.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_RELEASE_TICKS;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: an increment hold shorter than the long press, then a select.
        press_and_release(1'b1, 1'b0, 40, 102, 1'b0);
        press_and_release(1'b0, 1'b1, 3, 101, 1'b0);
        drain();

        // Directed ticks with tiny settings.
        set_cfg(16'd2, 16'd3, 16'd1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        // Both keys: increment wins, then held into auto-repeat.
        repeat (5) push_tick(1'b1, 1'b1);
        repeat (3) push_tick(1'b1, 1'b0);
        // Select alone in auto-repeat counts as released.
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        // Select held into auto-repeat, which it cannot feed.
        repeat (5) push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        drain();

        // Release counts of zero and one both act as one.
        set_cfg(16'd0, 16'd0, 16'd0);
        set_idling(68, 0);
        gen_bursts(60);
        drain();
        set_cfg(16'd1, 16'd1, 16'd1);
        set_idling(0, 68);
        gen_bursts(60);
        drain();

        // Top values: the release counter saturates, a long press can't repeat.
        set_cfg({9'($urandom_range(511)), 7'd127}, 16'hFFFF, 16'd65000);
        set_idling(15, 15);
        press_and_release(1'b1, 1'b0, 30, 135, 1'b0);
        drain();
        set_cfg(16'd126, 16'd65000, 16'hFFFF);
        set_idling(0, 0);
        press_and_release(1'b1, 1'b1, 20, 130, 1'b0);
        drain();

        // Random settings under each idling pattern; the first has a long stall.
        for (int p = 0; p < 4; p++) begin
            set_cfg(CFG_W'($urandom_range(8, 2)), CFG_W'($urandom_range(24, 1)),
                    CFG_W'($urandom_range(6, 1)));
            case (p)
                0: set_idling(0, 0);
                1: set_idling(68, 0);
                2: set_idling(0, 68);
                default: set_idling(15, 15);
            endcase
            gen_bursts(70);
            if (p == 0) begin
                @(posedge i_clk);
                holdoff_req <= holdoff_req + 1;
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
